// ===== design/wifi_retry_backoff_tracker_assert.svh =====
// Assertion macros used by the retry tracker top level.
`ifndef WIFI_RETRY_BACKOFF_TRACKER_ASSERT_SVH
`define WIFI_RETRY_BACKOFF_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS

// cond holds at every clock edge outside reset
`define WRB_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("wrb assertion failed");

// cons holds in the same cycle as ante
`define WRB_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wrb assertion failed");

// cons holds in the cycle after ante
`define WRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wrb assertion failed");

`else

`define WRB_ASSERT_ALWAYS(label, clk, rst, cond)
`define WRB_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define WRB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/wrb_pkg.sv =====
// Types, codes and helpers of the retry backoff tracker.
package wrb_pkg;

   // request commands
   localparam logic [1:0] CMD_SUCCESS = 2'd0;
   localparam logic [1:0] CMD_FAILURE = 2'd1;
   localparam logic [1:0] CMD_MCAST   = 2'd2;
   localparam logic [1:0] CMD_QUERY   = 2'd3;

   // frame kinds
   localparam logic [1:0] KIND_RTS   = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_QOS   = 2'd2;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   // response status
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BAD_KIND = 2'd1;
   localparam logic [1:0] STAT_NO_ENTRY = 2'd2;
   localparam logic [1:0] STAT_FULL     = 2'd3;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_LIMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RTS_THRESH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CW_MIN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CW_MAX      = 3'd4;
   localparam int CSR_DATA_W = 16;

   localparam int CW_W  = 15;
   localparam int CNT_W = 8;
   localparam int KEY_W = 32;

   localparam logic [CNT_W-1:0] SHORT_LIMIT_RESET = 8'd7;
   localparam logic [CNT_W-1:0] LONG_LIMIT_RESET  = 8'd4;
   localparam logic [15:0]      RTS_THRESH_RESET  = 16'hFFFF;
   localparam logic [CW_W-1:0]  CW_MIN_RESET      = 15'd15;
   localparam logic [CW_W-1:0]  CW_MAX_RESET      = 15'd1023;

   typedef struct packed {
      logic [CNT_W-1:0] short_limit;
      logic [CNT_W-1:0] long_limit;
      logic [15:0]      rts_threshold;
      logic [CW_W-1:0]  cw_min;
      logic [CW_W-1:0]  cw_max;
   } cfg_type;

   // station counter update for one request
   typedef struct packed {
      logic clr_short;
      logic clr_long;
      logic bump_short;
      logic bump_long;
      logic cw_reset;
   } station_op_type;

   // one row of the retry table memory
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] short_cnt;
      logic [CNT_W-1:0] long_cnt;
   } row_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
   endfunction

endpackage

// ===== design/wifi_retry_backoff_tracker.sv =====
// Top level of the 802.11 transmit retry and backoff tracker.
// One request is in work at a time. Success, multicast and unknown-kind
// requests pass from acceptance through the finish and done states to the
// response register. Failures and queries scan the retry table memory one
// entry per cycle through its single read port; a hit ends the scan early,
// else it runs to the last entry, and the finish and done states follow.
// The block takes the next request once the response is loaded. The
// response sits in an output register and a stalled response holds the next
// one in the last stage. Station counters and the window update at acceptance;
// register writes belong in gaps where no request is in work.
module wifi_retry_backoff_tracker #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic [1:0]                          req_frame_kind,
   input  logic [15:0]                         req_frame_length,
   input  logic [31:0]                         req_frame_id,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [14:0]                         rsp_contention_window,
   output logic [7:0]                          rsp_station_short_count,
   output logic [7:0]                          rsp_station_long_count,
   output logic                                rsp_retry_allowed,
   output logic [1:0]                          rsp_status,

   input  logic                                csr_we,
   input  logic [wrb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wrb_pkg::CSR_DATA_W-1:0]      csr_wdata
);

`include "wifi_retry_backoff_tracker_assert.svh"

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SCN_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type                   state_ff, state_in;
   wrb_pkg::cfg_type            cfg_ff, cfg_in;

   logic                        req_fire;
   logic                        req_long;
   wrb_pkg::station_op_type     st_op;
   logic [wrb_pkg::CW_W-1:0]    st_cw;
   logic [wrb_pkg::CNT_W-1:0]   st_short, st_long;

   // latched request
   logic [1:0]                  cmd_ff, cmd_in;
   logic                        use_long_ff, use_long_in;
   logic [wrb_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [1:0]                  base_status_ff, base_status_in;

   // table scan
   logic [SCN_W-1:0]            issue_ff, issue_in;
   logic                        chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]            chk_idx_ff, chk_idx_in;
   logic                        hit_ff, hit_in;
   logic [IDX_W-1:0]            hit_idx_ff, hit_idx_in;
   logic                        free_found_ff, free_found_in;
   logic [IDX_W-1:0]            free_idx_ff, free_idx_in;
   logic [wrb_pkg::CNT_W-1:0]   cap_short_ff, cap_short_in;
   logic [wrb_pkg::CNT_W-1:0]   cap_long_ff, cap_long_in;
   logic                        hit_now;
   logic                        scan_last;

   // per-entry valid bits
   logic [TABLE_DEPTH-1:0]      used_ff, used_in;
   logic [TABLE_DEPTH-1:0]      short_p_ff, short_p_in;
   logic [TABLE_DEPTH-1:0]      long_p_ff, long_p_in;

   // memory ports
   logic                        mem_rd_en;
   wrb_pkg::row_type            mem_rd_data;
   logic                        mem_wr_en;
   logic [IDX_W-1:0]            mem_wr_idx;
   wrb_pkg::row_type            mem_wr_data;

   // finish-stage values
   logic                        present_sel;
   logic [wrb_pkg::CNT_W-1:0]   cnt_sel;
   logic [wrb_pkg::CNT_W-1:0]   limit_sel;
   logic [wrb_pkg::CNT_W-1:0]   new_cnt;
   logic                        is_fail_ff;

   // response
   logic [1:0]                  res_status_ff, res_status_in;
   logic                        res_allowed_ff, res_allowed_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_load;
   logic [14:0]                 rsp_cw_ff;
   logic [7:0]                  rsp_short_ff, rsp_long_ff;
   logic                        rsp_allowed_ff;
   logic [1:0]                  rsp_status_ff;

   // ---------------- configuration ----------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            wrb_pkg::CSR_SHORT_LIMIT: cfg_in.short_limit   = csr_wdata[7:0];
            wrb_pkg::CSR_LONG_LIMIT:  cfg_in.long_limit    = csr_wdata[7:0];
            wrb_pkg::CSR_RTS_THRESH:  cfg_in.rts_threshold = csr_wdata;
            wrb_pkg::CSR_CW_MIN:      cfg_in.cw_min        = csr_wdata[14:0];
            wrb_pkg::CSR_CW_MAX:      cfg_in.cw_max        = csr_wdata[14:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   // ---------------- request decode ----------------
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign req_long  = ((req_frame_kind == wrb_pkg::KIND_DATA) ||
                       (req_frame_kind == wrb_pkg::KIND_QOS)) &&
                      (req_frame_length >= cfg_ff.rts_threshold);

   always_comb begin
      logic known;
      known = (req_frame_kind != wrb_pkg::KIND_OTHER);
      st_op.clr_short  = (req_cmd == wrb_pkg::CMD_MCAST) ||
                         ((req_cmd == wrb_pkg::CMD_SUCCESS) && known && !req_long);
      st_op.clr_long   = (req_cmd == wrb_pkg::CMD_MCAST) ||
                         ((req_cmd == wrb_pkg::CMD_SUCCESS) && known && req_long);
      st_op.cw_reset   = (req_cmd == wrb_pkg::CMD_SUCCESS) &&
                         ((req_frame_kind == wrb_pkg::KIND_DATA) ||
                          (req_frame_kind == wrb_pkg::KIND_QOS));
      st_op.bump_short = (req_cmd == wrb_pkg::CMD_FAILURE) && known && !req_long;
      st_op.bump_long  = (req_cmd == wrb_pkg::CMD_FAILURE) && known && req_long;
   end

   wrb_station u_station (
      .clock       (clock),
      .reset       (reset),
      .op_en       (req_fire),
      .op          (st_op),
      .cfg         (cfg_ff),
      .cw          (st_cw),
      .short_count (st_short),
      .long_count  (st_long)
   );

   // ---------------- table memory ----------------
   assign mem_rd_en = (state_ff == ST_SCAN) && (issue_ff < SCN_W'(TABLE_DEPTH));

   wrb_table_ram #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_idx),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (mem_rd_data)
   );

   assign hit_now   = chk_valid_ff && used_ff[chk_idx_ff] && (mem_rd_data.key == key_ff);
   assign scan_last = chk_valid_ff && (chk_idx_ff == IDX_W'(TABLE_DEPTH - 1));

   // ---------------- finish-stage datapath ----------------
   assign is_fail_ff  = (cmd_ff == wrb_pkg::CMD_FAILURE);
   assign present_sel = use_long_ff ? long_p_ff[hit_idx_ff] : short_p_ff[hit_idx_ff];
   assign cnt_sel     = use_long_ff ? cap_long_ff : cap_short_ff;
   assign limit_sel   = use_long_ff ? cfg_ff.long_limit : cfg_ff.short_limit;
   // first failure enters the count as zero
   assign new_cnt     = (hit_ff && present_sel) ? wrb_pkg::sat_inc(cnt_sel) : '0;
   assign mem_wr_idx  = hit_ff ? hit_idx_ff : free_idx_ff;
   assign mem_wr_en   = (state_ff == ST_FINISH) && (base_status_ff == wrb_pkg::STAT_OK) &&
                        is_fail_ff && (hit_ff || free_found_ff);

   always_comb begin
      mem_wr_data.key       = key_ff;
      mem_wr_data.short_cnt = use_long_ff ? cap_short_ff : new_cnt;
      mem_wr_data.long_cnt  = use_long_ff ? new_cnt : cap_long_ff;
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // ---------------- control ----------------
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      use_long_in    = use_long_ff;
      key_in         = key_ff;
      base_status_in = base_status_ff;
      issue_in       = issue_ff;
      chk_valid_in   = mem_rd_en;
      chk_idx_in     = issue_ff[IDX_W-1:0];
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      cap_short_in   = cap_short_ff;
      cap_long_in    = cap_long_ff;
      used_in        = used_ff;
      short_p_in     = short_p_ff;
      long_p_in      = long_p_ff;
      res_status_in  = res_status_ff;
      res_allowed_in = res_allowed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in        = req_cmd;
               use_long_in   = req_long;
               key_in        = req_frame_id;
               issue_in      = '0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               if (req_cmd == wrb_pkg::CMD_MCAST) begin
                  base_status_in = wrb_pkg::STAT_OK;
                  state_in       = ST_FINISH;
               end else if (req_frame_kind == wrb_pkg::KIND_OTHER) begin
                  base_status_in = wrb_pkg::STAT_BAD_KIND;
                  state_in       = ST_FINISH;
               end else if (req_cmd == wrb_pkg::CMD_SUCCESS) begin
                  base_status_in = wrb_pkg::STAT_OK;
                  state_in       = ST_FINISH;
               end else begin
                  base_status_in = wrb_pkg::STAT_OK;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (mem_rd_en) begin
               issue_in = issue_ff + SCN_W'(1);
            end
            if (hit_now) begin
               hit_in       = 1'b1;
               hit_idx_in   = chk_idx_ff;
               cap_short_in = mem_rd_data.short_cnt;
               cap_long_in  = mem_rd_data.long_cnt;
               state_in     = ST_FINISH;
            end else begin
               // remember the lowest free slot for a new entry
               if (chk_valid_ff && !used_ff[chk_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = chk_idx_ff;
               end
               if (scan_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            res_status_in  = base_status_ff;
            res_allowed_in = 1'b0;
            if (base_status_ff == wrb_pkg::STAT_OK) begin
               if (cmd_ff == wrb_pkg::CMD_QUERY) begin
                  if (!hit_ff || !present_sel) begin
                     res_status_in = wrb_pkg::STAT_NO_ENTRY;
                  end else begin
                     res_allowed_in = (cnt_sel < limit_sel);
                  end
               end else if (is_fail_ff) begin
                  if (hit_ff) begin
                     if (use_long_ff) begin
                        long_p_in[mem_wr_idx] = 1'b1;
                     end else begin
                        short_p_in[mem_wr_idx] = 1'b1;
                     end
                  end else if (free_found_ff) begin
                     used_in[mem_wr_idx]    = 1'b1;
                     short_p_in[mem_wr_idx] = !use_long_ff;
                     long_p_in[mem_wr_idx]  = use_long_ff;
                  end else begin
                     res_status_in = wrb_pkg::STAT_FULL;
                  end
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cfg_ff.short_limit   <= wrb_pkg::SHORT_LIMIT_RESET;
         cfg_ff.long_limit    <= wrb_pkg::LONG_LIMIT_RESET;
         cfg_ff.rts_threshold <= wrb_pkg::RTS_THRESH_RESET;
         cfg_ff.cw_min        <= wrb_pkg::CW_MIN_RESET;
         cfg_ff.cw_max        <= wrb_pkg::CW_MAX_RESET;
         issue_ff      <= '0;
         chk_valid_ff  <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         used_ff       <= '0;
         short_p_ff    <= '0;
         long_p_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_ff        <= cfg_in;
         issue_ff      <= issue_in;
         chk_valid_ff  <= chk_valid_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         used_ff       <= used_in;
         short_p_ff    <= short_p_in;
         long_p_ff     <= long_p_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      use_long_ff    <= use_long_in;
      key_ff         <= key_in;
      base_status_ff <= base_status_in;
      chk_idx_ff     <= chk_idx_in;
      hit_idx_ff     <= hit_idx_in;
      free_idx_ff    <= free_idx_in;
      cap_short_ff   <= cap_short_in;
      cap_long_ff    <= cap_long_in;
      res_status_ff  <= res_status_in;
      res_allowed_ff <= res_allowed_in;
      if (rsp_load) begin
         rsp_cw_ff      <= st_cw;
         rsp_short_ff   <= st_short;
         rsp_long_ff    <= st_long;
         rsp_allowed_ff <= res_allowed_ff;
         rsp_status_ff  <= res_status_ff;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_contention_window   = rsp_cw_ff;
   assign rsp_station_short_count = rsp_short_ff;
   assign rsp_station_long_count  = rsp_long_ff;
   assign rsp_retry_allowed       = rsp_allowed_ff;
   assign rsp_status              = rsp_status_ff;

   // ---------------- assertions ----------------
   `WRB_ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire, state_ff != ST_IDLE)
   `WRB_ASSERT_ALWAYS(a_present_needs_used, clock, reset,
                      (~used_ff & (short_p_ff | long_p_ff)) == '0)
   `WRB_ASSERT_IMPLIES(a_new_entry_free, clock, reset, mem_wr_en && !hit_ff,
                       !used_ff[free_idx_ff])
   `WRB_ASSERT_NEXT(a_hit_ends_scan, clock, reset, (state_ff == ST_SCAN) && hit_now,
                    state_ff == ST_FINISH)
   `WRB_ASSERT_NEXT(a_rsp_loaded, clock, reset, rsp_load, rsp_valid_ff)

endmodule

// ===== design/wrb_table_ram.sv =====
// Retry table storage: one write port, one registered read port.
module wrb_table_ram #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  wrb_pkg::row_type  wr_data,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output wrb_pkg::row_type  rd_data
);

   wrb_pkg::row_type mem_ff [DEPTH];
   wrb_pkg::row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/wrb_station.sv =====
// Station short/long retry counters and contention window.
module wrb_station (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        op_en,
   input  wrb_pkg::station_op_type     op,
   input  wrb_pkg::cfg_type            cfg,
   output logic [wrb_pkg::CW_W-1:0]    cw,
   output logic [wrb_pkg::CNT_W-1:0]   short_count,
   output logic [wrb_pkg::CNT_W-1:0]   long_count
);

   logic [wrb_pkg::CW_W-1:0]  cw_ff, cw_in;
   logic [wrb_pkg::CNT_W-1:0] short_ff, short_in;
   logic [wrb_pkg::CNT_W-1:0] long_ff, long_in;
   logic [wrb_pkg::CNT_W-1:0] short_inc, long_inc;
   logic [wrb_pkg::CW_W:0]    cw_dbl_wide;
   logic [wrb_pkg::CW_W-1:0]  cw_dbl;

   assign short_inc   = wrb_pkg::sat_inc(short_ff);
   assign long_inc    = wrb_pkg::sat_inc(long_ff);
   // 2*cw+1, clipped to cw_max
   assign cw_dbl_wide = {cw_ff, 1'b1};
   assign cw_dbl      = (cw_dbl_wide > {1'b0, cfg.cw_max}) ? cfg.cw_max
                                                           : cw_dbl_wide[wrb_pkg::CW_W-1:0];

   always_comb begin
      cw_in    = cw_ff;
      short_in = short_ff;
      long_in  = long_ff;
      if (op_en) begin
         if (op.clr_short) begin
            short_in = '0;
         end
         if (op.clr_long) begin
            long_in = '0;
         end
         if (op.cw_reset) begin
            cw_in = cfg.cw_min;
         end
         if (op.bump_short) begin
            short_in = short_inc;
            cw_in    = (short_inc == cfg.short_limit) ? cfg.cw_min : cw_dbl;
         end
         if (op.bump_long) begin
            long_in = long_inc;
            cw_in   = (long_inc == cfg.long_limit) ? cfg.cw_min : cw_dbl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff    <= wrb_pkg::CW_MIN_RESET;
         short_ff <= '0;
         long_ff  <= '0;
      end else begin
         cw_ff    <= cw_in;
         short_ff <= short_in;
         long_ff  <= long_in;
      end
   end

   assign cw          = cw_ff;
   assign short_count = short_ff;
   assign long_count  = long_ff;

endmodule
